[sv/lin_exp_log_ramp_generator_defines.svh]
// ----------------------------------------------------------------------------
// Ramp generator assertion macros
// Shared concurrent assertion forms for the ramp generator. Each expects the
// signals clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LIN_EXP_LOG_RAMP_GENERATOR_DEFINES_SVH
`define LIN_EXP_LOG_RAMP_GENERATOR_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LELRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LELRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lelrg_pkg.sv]
// ----------------------------------------------------------------------------
// Ramp generator package
// Sequencer states, register indexes, curve codes and fixed constants.
// ----------------------------------------------------------------------------
package lelrg_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_DIR     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_ENABLE = 2'd2;

  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_EXP    = 2'd1;
  localparam logic [1:0] CURVE_LOG    = 2'd2;

  // log10(2)/2 as an unsigned Q0.32 value.
  localparam logic [31:0] LOG10_2_HALF_Q32 = 32'd646456993;

  // Binary point of the normalized mantissa used by the log2 squaring loop.
  localparam int MANT_POINT = 30;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_PREP,
    S_DIV,
    S_SHAPE,
    S_NORM,
    S_LOG_SQ,
    S_LOG_MAG,
    S_LOG_RES,
    S_SCALE,
    S_OUT
  } state_t;

endpackage

[sv/lin_exp_log_ramp_generator.sv]
// ----------------------------------------------------------------------------
// Linear / exponential / logarithmic ramp generator
// Each input beat on s_axis is one evaluation: tdata carries now_tick,
// duration_ticks, scale_low and scale_high. When the previous segment has
// ended, a new one starts at now_tick and lasts duration_ticks. The result
// beat on m_axis carries the shaped, range-mapped level in tdata and marks
// the beat that ended a segment with tlast.
// An evaluation runs FRAC_BITS division steps and FRAC_BITS mantissa
// squarings one per cycle through a single divider step and a single
// registered multiplier. Linear curves skip the squaring loop, and an
// evaluation that ends its segment skips the division steps.
// s_axis_tready is high only while the sequencer is idle, so the next beat
// is accepted at the earliest in the cycle in which the result appears.
// The result sits in an output register; a stalled receiver holds it
// there while the next beat is accepted and computed. The sequencer waits
// only if a second result is ready before the first was taken.
// Configuration writes on the cfg channel are always accepted. Reset clears
// the sequencer state, the configuration and segment registers and the
// output valid flag, and arms the first segment.
// ----------------------------------------------------------------------------
module lin_exp_log_ramp_generator import lelrg_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // now_tick [31:0], duration_ticks [63:32], scale_low [95:64],
  // scale_high [127:96]
  input  logic [127:0]           s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // level [31:0]
  output logic [31:0]            m_axis_tdata,
  output logic                   m_axis_tlast
);

`include "lin_exp_log_ramp_generator_defines.svh"

  localparam int CW    = FRAC_BITS + 1;
  localparam int EW    = $clog2(FRAC_BITS + 1);
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS - 1);

  state_t state, state_next;

  logic [1:0] curve_mode;
  logic       initial_direction;
  logic       scale_enable;

  logic                  ramp_direction;
  logic                  first_segment;
  logic                  seg_finished;
  logic [TIME_WIDTH-1:0] seg_start;
  logic [TIME_WIDTH-1:0] seg_length;

  logic [TIME_WIDTH-1:0] now_r;
  logic [TIME_WIDTH-1:0] dur_r;
  logic signed [31:0]    lo_in;
  logic signed [31:0]    hi_in;
  logic signed [31:0]    lo_r;
  logic [31:0]           diff;

  logic [TIME_WIDTH-1:0] rem;
  logic [CW-1:0]         p;
  logic [CW-1:0]         x_r;
  logic [CW-1:0]         c;
  logic [EW-1:0]         e_r;
  logic [FRAC_BITS-1:0]  frac;
  logic [CNT_W-1:0]      cnt;
  logic                  done_r;

  logic                  out_valid;
  logic [31:0]           out_level;
  logic                  out_last;

  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH:0]   rem_two;
  logic                  div_ge;
  logic [CW-1:0]         p_dir;
  logic [CW-1:0]         x_exp;
  logic [EW-1:0]         e_find;
  logic [31:0]           m_init;
  logic [31:0]           sq_t;
  logic                  sq_bit;
  logic [31:0]           sq_src;
  logic [FRAC_BITS-1:0]  frac_full;
  logic [31:0]           mag;
  logic [31:0]           c_raw;
  logic [63:0]           c_wide;
  logic [31:0]           level_calc;
  logic                  out_free;

  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  lelrg_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_level;
  assign m_axis_tlast  = out_last;

  assign lo_in    = s_axis_tdata[95:64];
  assign hi_in    = s_axis_tdata[127:96];
  assign out_free = !out_valid || m_axis_tready;

  assign elapsed = now_r - seg_start;
  assign rem_two = {rem, 1'b0};
  assign div_ge  = rem_two >= {1'b0, seg_length};
  assign p_dir   = ramp_direction ? (ONE - p) : p;
  assign x_exp   = ONE - p_dir;

  always_comb begin
    e_find = '0;
    for (int i = 0; i <= FRAC_BITS; i++) begin
      if (x_r[i]) begin
        e_find = EW'(i);
      end
    end
  end

  assign m_init    = 32'(x_r) << (MANT_POINT - int'(e_r));
  assign sq_t      = prod[61:30];
  assign sq_bit    = sq_t[31];
  assign sq_src    = sq_bit ? {1'b0, sq_t[31:1]} : sq_t;
  assign frac_full = {frac[FRAC_BITS-2:0], sq_bit};
  assign mag       = ((32'(FRAC_BITS) - 32'(e_r)) << FRAC_BITS) - 32'(frac_full);
  assign c_raw     = prod[63:32];
  assign c_wide    = 64'(c);

  always_comb begin
    if (scale_enable) begin
      level_calc = 32'(prod >> FRAC_BITS) + lo_r;
    end else begin
      level_calc = 32'((c_wide << 16) >> FRAC_BITS);
    end
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_LOG_SQ: begin
        mul_en = 1'b1;
        mul_a  = (cnt == '0) ? m_init : sq_src;
        mul_b  = (cnt == '0) ? m_init : sq_src;
      end
      S_LOG_MAG: begin
        mul_en = 1'b1;
        mul_a  = mag;
        mul_b  = LOG10_2_HALF_Q32;
      end
      S_SCALE: begin
        mul_en = 1'b1;
        mul_a  = 32'(c);
        mul_b  = diff;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: state_next = S_PREP;
      S_PREP: begin
        state_next = (elapsed >= seg_length) ? S_SHAPE : S_DIV;
      end
      S_DIV: begin
        if (cnt == LAST_STEP) begin
          state_next = S_SHAPE;
        end
      end
      S_SHAPE: begin
        if (curve_mode == CURVE_EXP) begin
          state_next = (x_exp == '0) ? S_SCALE : S_NORM;
        end else if (curve_mode == CURVE_LOG) begin
          state_next = (p_dir == '0) ? S_SCALE : S_NORM;
        end else begin
          state_next = S_SCALE;
        end
      end
      S_NORM: state_next = S_LOG_SQ;
      S_LOG_SQ: begin
        if (cnt == LAST_STEP) begin
          state_next = S_LOG_MAG;
        end
      end
      S_LOG_MAG: state_next = S_LOG_RES;
      S_LOG_RES: state_next = S_SCALE;
      S_SCALE:   state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode        <= CURVE_LINEAR;
      initial_direction <= 1'b0;
      scale_enable      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURVE_MODE:   curve_mode <= cfg_data[1:0];
        CFG_INIT_DIR:     initial_direction <= cfg_data[0];
        CFG_SCALE_ENABLE: scale_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_direction <= 1'b0;
      first_segment  <= 1'b1;
      seg_finished   <= 1'b1;
      seg_start      <= '0;
      seg_length     <= '0;
    end else begin
      if (state == S_SETUP && seg_finished) begin
        seg_start    <= now_r;
        seg_length   <= dur_r;
        seg_finished <= 1'b0;
        if (first_segment) begin
          ramp_direction <= initial_direction;
          first_segment  <= 1'b0;
        end
      end
      if (state == S_OUT && out_free && done_r) begin
        ramp_direction <= !ramp_direction;
        seg_finished   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_level <= level_calc;
      out_last  <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          now_r <= TIME_WIDTH'(s_axis_tdata[31:0]);
          dur_r <= TIME_WIDTH'(s_axis_tdata[63:32]);
          if (hi_in < lo_in) begin
            lo_r <= hi_in;
            diff <= 32'(33'(lo_in) - 33'(hi_in));
          end else begin
            lo_r <= lo_in;
            diff <= 32'(33'(hi_in) - 33'(lo_in));
          end
        end
      end
      S_PREP: begin
        rem    <= elapsed;
        cnt    <= '0;
        done_r <= (elapsed >= seg_length);
        p      <= (elapsed >= seg_length) ? ONE : '0;
      end
      S_DIV: begin
        cnt <= cnt + 1'b1;
        p   <= {p[CW-2:0], div_ge};
        if (div_ge) begin
          rem <= TIME_WIDTH'(rem_two - {1'b0, seg_length});
        end else begin
          rem <= rem_two[TIME_WIDTH-1:0];
        end
      end
      S_SHAPE: begin
        if (curve_mode == CURVE_EXP) begin
          x_r <= x_exp;
          c   <= ONE;
        end else if (curve_mode == CURVE_LOG) begin
          x_r <= p_dir;
          c   <= '0;
        end else begin
          c <= p_dir;
        end
      end
      S_NORM: begin
        e_r <= e_find;
        cnt <= '0;
      end
      S_LOG_SQ: begin
        if (cnt != '0) begin
          frac <= {frac[FRAC_BITS-2:0], sq_bit};
        end
        cnt <= cnt + 1'b1;
      end
      S_LOG_RES: begin
        if (curve_mode == CURVE_EXP) begin
          c <= (c_raw > 32'(ONE)) ? ONE : CW'(c_raw);
        end else begin
          c <= (c_raw >= 32'(ONE)) ? '0 : CW'(32'(ONE) - c_raw);
        end
      end
      default: begin
      end
    endcase
  end

  `LELRG_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an evaluation was running")
  `LELRG_ASSERT_NOW(a_shape_in_range, state == S_SCALE, c <= ONE, "shaped value above one")
  `LELRG_ASSERT_NOW(a_square_normalized, state == S_LOG_SQ && cnt != '0, sq_t >= 32'h4000_0000, "mantissa square lost normalization")
  `LELRG_ASSERT_NEXT(a_segment_rearm, state == S_OUT && out_free && done_r, seg_finished, "segment end did not arm a new segment")

endmodule

[sv/lelrg_mul.sv]
// ----------------------------------------------------------------------------
// Ramp generator shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product, reused for
// mantissa squaring, log scaling and the final range mapping.
// ----------------------------------------------------------------------------
module lelrg_mul import lelrg_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 64'(a) * 64'(b);
    end
  end

endmodule

[tb/tb_lin_exp_log_ramp_generator.sv]
// ----------------------------------------------------------------------------
// Ramp generator testbench
// Drives evaluation beats into the ramp generator with random gaps on both
// stream sides. A scoreboard keeps its own model of the segment timing,
// the curve shaping and the scale mapping, and checks every result beat.
// A short directed run covers the corner cases. Random phases follow,
// each under its own register settings.
// ----------------------------------------------------------------------------
module tb_lin_exp_log_ramp_generator;
  import lelrg_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0] CURVE_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 85;

  typedef struct packed {
    logic [31:0] scale_high;
    logic [31:0] scale_low;
    logic [31:0] duration_ticks;
    logic [31:0] now_tick;
  } ramp_eval_t;

  typedef struct {
    logic [31:0] level;
    logic        done;
  } ramp_level_t;

  class ramp_scoreboard;
    ramp_level_t levels_due[$];
    int errors;
    int n_evals;
    int n_checked;
    int n_seg_ends;
    logic [1:0] curve_sel;
    logic start_falling;
    logic use_scale;
    logic falling;
    logic first_seg;
    logic seg_over;
    logic [31:0] seg_start;
    logic [31:0] seg_len;

    function new();
      curve_sel = CURVE_LINEAR;
      start_falling = 1'b0;
      use_scale = 1'b0;
      falling = 1'b0;
      first_seg = 1'b1;
      seg_over = 1'b1;
      seg_start = '0;
      seg_len = '0;
      errors = 0;
      n_evals = 0;
      n_checked = 0;
      n_seg_ends = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CURVE_MODE: curve_sel = val;
        CFG_INIT_DIR: start_falling = val[0];
        CFG_SCALE_ENABLE: use_scale = val[0];
        default: ;
      endcase
    endfunction

    // Half of -log10(x / 2^16) in Q48.16 for 1 <= x <= 2^16, via log2 by squaring.
    function logic [63:0] half_neg_log10(logic [63:0] x);
      int msb;
      int i;
      logic [63:0] mant;
      logic [63:0] bits;
      logic [63:0] mag;
      msb = 0;
      for (i = 1; i < 64; i++) begin
        if ((x >> i) != 0) msb = i;
      end
      mant = x << (MANT_POINT - msb);
      bits = '0;
      for (i = 0; i < FRAC; i++) begin
        mant = (mant * mant) >> MANT_POINT;
        bits = bits << 1;
        if (mant >= (64'd1 << (MANT_POINT + 1))) begin
          bits[0] = 1'b1;
          mant = mant >> 1;
        end
      end
      mag = 64'(FRAC - msb) * ONE_Q - bits;
      return (mag * 64'(LOG10_2_HALF_Q32)) >> 32;
    endfunction

    function void take_eval(ramp_eval_t ev);
      logic [31:0] elapsed;
      logic [63:0] prog;
      logic [63:0] shaped;
      logic [63:0] depth;
      logic [63:0] span;
      longint lo;
      longint hi;
      longint swap;
      longint lvl;
      logic done;
      ramp_level_t res;
      if (seg_over) begin
        seg_start = ev.now_tick;
        seg_len = ev.duration_ticks;
        if (first_seg) begin
          falling = start_falling;
          first_seg = 1'b0;
        end
        seg_over = 1'b0;
      end
      elapsed = ev.now_tick - seg_start;
      done = (elapsed >= seg_len);
      prog = done ? ONE_Q : ({32'd0, elapsed} << FRAC) / {32'd0, seg_len};
      if (falling) prog = ONE_Q - prog;
      case (curve_sel)
        CURVE_EXP: begin
          depth = ONE_Q - prog;
          shaped = (depth == 0) ? ONE_Q : half_neg_log10(depth);
          if (shaped > ONE_Q) shaped = ONE_Q;
        end
        CURVE_LOG: begin
          depth = (prog == 0) ? ONE_Q : half_neg_log10(prog);
          shaped = (depth >= ONE_Q) ? 64'd0 : ONE_Q - depth;
        end
        default: shaped = prog;
      endcase
      if (use_scale) begin
        lo = longint'($signed(ev.scale_low));
        hi = longint'($signed(ev.scale_high));
        if (hi < lo) begin
          swap = hi;
          hi = lo;
          lo = swap;
        end
        span = 64'(hi - lo);
        lvl = longint'((shaped * span) >> FRAC) + lo;
      end else begin
        lvl = longint'(shaped);
      end
      if (done) begin
        falling = ~falling;
        seg_over = 1'b1;
      end
      res.level = lvl[31:0];
      res.done = done;
      levels_due.push_back(res);
      n_evals++;
    endfunction

    function void check_beat(logic [31:0] level, logic last);
      ramp_level_t want;
      if (levels_due.size() == 0) begin
        $error("result beat with no evaluation pending: level %h", level);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      n_checked++;
      if (want.done) n_seg_ends++;
      if (level !== want.level) begin
        $error("level: expected %h, got %h", want.level, level);
        errors++;
      end
      if (last !== want.done) begin
        $error("segment_done: expected %b, got %b", want.done, last);
        errors++;
      end
    endfunction

    function int pending();
      return levels_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;

  ramp_scoreboard sb;
  bit calm;
  logic [31:0] tick;

  lin_exp_log_ramp_generator dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic ramp_eval_t eval_of(logic [31:0] now, logic [31:0] dur,
                                         logic [31:0] lo, logic [31:0] hi);
    ramp_eval_t ev;
    ev.now_tick = now;
    ev.duration_ticks = dur;
    ev.scale_low = lo;
    ev.scale_high = hi;
    return ev;
  endfunction

  // Mostly a tick that moves forward in small steps, with jumps and
  // backward steps mixed in.
  function automatic ramp_eval_t next_eval();
    ramp_eval_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) tick += $urandom_range(0, 6);
    else if (pick < 90) tick += $urandom_range(7, 64);
    else if (pick < 97) tick = $urandom;
    else tick -= $urandom_range(1, 16);
    ev.now_tick = tick;
    pick = $urandom_range(0, 99);
    if (pick < 10) ev.duration_ticks = '0;
    else if (pick < 60) ev.duration_ticks = $urandom_range(1, 16);
    else if (pick < 88) ev.duration_ticks = $urandom_range(17, 300);
    else ev.duration_ticks = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      ev.scale_low = $urandom;
      ev.scale_high = $urandom;
    end else if (pick < 85) begin
      ev.scale_low = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      ev.scale_high = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    end else begin
      ev.scale_low = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      ev.scale_high = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return ev;
  endfunction

  task automatic apply_settings(input logic [1:0] curve, input logic dir,
                                input logic scale);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] vals [4];
    int k;
    idx = '{CFG_CURVE_MODE, CFG_INIT_DIR, CFG_SCALE_ENABLE, CFG_SPARE};
    vals[0] = curve;
    vals[1] = {1'($urandom_range(0, 1)), dir};
    vals[2] = {1'($urandom_range(0, 1)), scale};
    vals[3] = 2'($urandom_range(0, 3));
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_reg(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_eval(input ramp_eval_t ev);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ev;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.take_eval(ev);
  endtask

  // Stops sending and waits until every expected result beat has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_beat(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    sb = new();
    calm = 1'b0;
    tick = '0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First segment falls from one; zero lengths and overshoot.
    apply_settings(CURVE_LINEAR, 1'b1, 1'b0);
    send_eval(eval_of(32'd0, 32'd4, 32'd0, 32'd0));
    send_eval(eval_of(32'd2, 32'd99, 32'd0, 32'd0));
    send_eval(eval_of(32'd4, 32'd0, 32'd0, 32'd0));
    send_eval(eval_of(32'd4, 32'd0, 32'd0, 32'd0));
    send_eval(eval_of(32'd100, 32'd10, 32'd0, 32'd0));
    send_eval(eval_of(32'd150, 32'd7, 32'd0, 32'd0));
    drain();

    // Exponential across the tick wrap, extreme, reversed and equal bounds.
    apply_settings(CURVE_EXP, 1'b0, 1'b1);
    send_eval(eval_of(32'hFFFF_FFF0, 32'd32, 32'h8000_0000, 32'h7FFF_FFFF));
    send_eval(eval_of(32'hFFFF_FFF8, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000));
    send_eval(eval_of(32'h0000_0008, 32'd1, 32'hFFFF_0000, 32'h0003_0000));
    send_eval(eval_of(32'h0000_0010, 32'd1, 32'h1234_5678, 32'h1234_5678));
    send_eval(eval_of(32'h0000_0020, 32'd5, 32'd0, 32'h0001_0000));
    drain();

    // Logarithmic, including zero progress at the end of a falling segment and the start of a rising one.
    apply_settings(CURVE_LOG, 1'b1, 1'b0);
    send_eval(eval_of(32'h0000_1000, 32'd16, 32'd0, 32'd0));
    send_eval(eval_of(32'h0000_2000, 32'd16, 32'd0, 32'd0));
    send_eval(eval_of(32'h0000_2001, 32'd16, 32'd0, 32'd0));
    send_eval(eval_of(32'h0000_2008, 32'd16, 32'd0, 32'd0));
    send_eval(eval_of(32'h0000_200F, 32'd16, 32'd0, 32'd0));
    send_eval(eval_of(32'h0000_2010, 32'd16, 32'd0, 32'd0));
    drain();

    // Spare curve code with the longest possible segment.
    apply_settings(CURVE_SPARE, 1'b0, 1'b1);
    send_eval(eval_of(32'h0000_3000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0001_0000));
    send_eval(eval_of(32'h8000_2FFF, 32'd0, 32'hFFFF_0000, 32'h0001_0000));
    send_eval(eval_of(32'h0000_2FFF, 32'd0, 32'hFFFF_0000, 32'h0001_0000));
    send_eval(eval_of(32'h0000_3000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF));
    drain();

    tick = $urandom;
    for (ph = 0; ph < 8; ph++) begin
      apply_settings(2'(ph % 4), 1'($urandom_range(0, 1)), (ph >= 2 && ph < 6));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        calm = (n >= 20 && n < 35);
        send_eval(next_eval());
      end
      calm = 1'b0;
      drain();
    end

    repeat (60) @(posedge clk);
    $display("Checked %0d of %0d evaluations, %0d of them ending a segment.",
             sb.n_checked, sb.n_evals, sb.n_seg_ends);
    $display("All four curve codes ran with and without scale bounds.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/lelrg_pkg.sv
sv/lelrg_mul.sv
sv/lin_exp_log_ramp_generator.sv
tb/tb_lin_exp_log_ramp_generator.sv
